### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/fhl_pkg.sv
// ---------------------------------------------------------------------------
// fhl_pkg
// constants, codes and types of the fire hotspot line generator
// ---------------------------------------------------------------------------
package fhl_pkg;

  localparam int HOTSPOTS   = 48;
  localparam int POS_W      = 10;
  localparam int CAP_W      = 8;
  localparam int IN_IDX_W   = 8;
  localparam int MODE_W     = 2;
  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam int HEAT_REACH        = 20;
  localparam int STEP_BIAS         = 3;
  localparam int LINE_WIDTH_RST    = 320;
  localparam int INTENSITY_CAP_RST = 192;

  localparam int IDX_W     = (HOTSPOTS > 1) ? $clog2(HOTSPOTS) : 1;
  localparam int CNT_W     = $clog2(HOTSPOTS + 1);
  localparam int HEAT_W    = $clog2(HEAT_REACH + 1);
  localparam int ACC_RAW_W = $clog2(HOTSPOTS * HEAT_REACH + 1);
  localparam int ACC_W     = (ACC_RAW_W > CAP_W) ? ACC_RAW_W : CAP_W;
  localparam int ALU_W     = ((ACC_W > POS_W + 1) ? ACC_W : POS_W + 1) + 1;

  localparam logic [IN_IDX_W:0] HOTSPOTS_L = (IN_IDX_W + 1)'(HOTSPOTS);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_RENDER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_CAP = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_HEAT
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [POS_W-1:0] spot;
    logic [POS_W-1:0] col;
  } alu_ctl_t;

endpackage

### src/fhl_ram.sv
// ---------------------------------------------------------------------------
// fhl_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module fhl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/fhl_alu.sv
// ---------------------------------------------------------------------------
// fhl_alu
// shared adder: plain add or subtract, or add of one hotspot's heat at a column
// ---------------------------------------------------------------------------
module fhl_alu import fhl_pkg::*; (
  input  alu_ctl_t                ctl,
  input  logic signed [ALU_W-1:0] a,
  input  logic signed [ALU_W-1:0] b,
  output logic signed [ALU_W-1:0] y
);

  logic [POS_W-1:0]  gap;
  logic [HEAT_W-1:0] heat;

  always_comb begin
    gap  = (ctl.spot > ctl.col) ? ctl.spot - ctl.col : ctl.col - ctl.spot;
    heat = (gap < POS_W'(HEAT_REACH)) ? HEAT_W'(POS_W'(HEAT_REACH) - gap) : '0;
    case (ctl.op)
      ALU_ADD:  y = a + b;
      ALU_SUB:  y = a - b;
      ALU_HEAT: y = a + $signed(ALU_W'(heat));
      default:  y = a;
    endcase
  end

endmodule

### src/fire_hotspot_line_generator.sv
// ---------------------------------------------------------------------------
// fire_hotspot_line_generator
// hotspot table of a fire effect's bottom line: load, move and render
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown for one cycle with done high and cannot be held off. Load, mode 3,
// clipped render columns and out-of-range hotspot requests give done on the
// next cycle and leave busy low.
// A move adds its step to the stored position and then wraps the sum into the
// line (one wrap step at most for line widths of 4 and above, up to four for
// narrower lines). A render reads the hotspot table, which sits in one ram
// with a single read port, and every stored position passes once through the
// one shared adder. Configuration writes take effect at once and belong in
// idle time.
// ---------------------------------------------------------------------------
module fire_hotspot_line_generator import fhl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    mode,
  input  logic [IN_IDX_W-1:0]  hotspot_index,
  input  logic [POS_W-1:0]     value,
  input  logic [POS_W-1:0]     column,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  output logic                 done,
  output logic [CAP_W-1:0]     intensity,
  output logic [POS_W-1:0]     position
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE_ADD,
    S_WRAP,
    S_RENDER
  } state_t;

  state_t                  state;
  logic [POS_W-1:0]        line_width;
  logic [CAP_W-1:0]        intensity_cap;
  logic [HOTSPOTS-1:0]     vld;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        rd_idx;
  logic [STEP_W-1:0]       step;
  logic [POS_W-1:0]        col;
  logic signed [ALU_W-1:0] p;
  logic [ACC_W-1:0]        acc;
  logic [CNT_W-1:0]        cnt;

  logic [POS_W-1:0]        w;
  logic [POS_W-1:0]        w_max;
  logic                    in_range;
  logic [POS_W-1:0]        load_pos;
  logic [POS_W-1:0]        spot;
  logic [POS_W-1:0]        cur_sat;
  logic signed [STEP_W:0]  step_adj;
  logic                    wrap_lo;
  logic                    wrap_hi;
  logic [ACC_W-1:0]        acc_sum;
  logic [CAP_W-1:0]        heat_capped;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [POS_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [POS_W-1:0]        ram_rdata;

  alu_ctl_t                alu_ctl;
  logic signed [ALU_W-1:0] alu_a;
  logic signed [ALU_W-1:0] alu_b;
  logic signed [ALU_W-1:0] alu_y;

  assign busy = (state != S_IDLE);

  always_comb begin
    w        = (line_width == '0) ? POS_W'(1) : line_width;
    w_max    = w - POS_W'(1);
    in_range = ({1'b0, hotspot_index} < HOTSPOTS_L);
    load_pos = (value > w_max) ? w_max : value;
    spot     = vld[rd_idx] ? ram_rdata : '0;
    cur_sat  = (spot > w_max) ? w_max : spot;
    step_adj = $signed({1'b0, step}) - $signed((STEP_W + 1)'(STEP_BIAS));
    wrap_lo  = p[ALU_W-1];
    wrap_hi  = !wrap_lo && (p >= $signed(ALU_W'(w)));

    // ram ports
    ram_we    = 1'b0;
    ram_waddr = hotspot_index[IDX_W-1:0];
    ram_wdata = load_pos;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (start && in_range && (mode == MODE_LOAD)) begin
          ram_we = 1'b1;
        end
        if (in_range && (mode == MODE_MOVE)) begin
          ram_raddr = hotspot_index[IDX_W-1:0];
        end
      end
      S_WRAP: begin
        ram_waddr = idx;
        ram_wdata = POS_W'(p);
        ram_we    = !wrap_lo && !wrap_hi;
      end
      S_RENDER: begin
        if (cnt < CNT_W'(HOTSPOTS)) begin
          ram_raddr = cnt[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase

    // shared adder operands
    alu_ctl.op   = ALU_ADD;
    alu_ctl.spot = spot;
    alu_ctl.col  = col;
    alu_a        = p;
    alu_b        = '0;
    case (state)
      S_MOVE_ADD: begin
        alu_a = $signed(ALU_W'(cur_sat));
        alu_b = ALU_W'(step_adj);
      end
      S_WRAP: begin
        alu_ctl.op = wrap_lo ? ALU_ADD : ALU_SUB;
        alu_b      = $signed(ALU_W'(w));
      end
      S_RENDER: begin
        alu_ctl.op = ALU_HEAT;
        alu_a      = $signed(ALU_W'(acc));
      end
      default: begin
      end
    endcase

    acc_sum     = ACC_W'(alu_y);
    heat_capped = (acc_sum > ACC_W'(intensity_cap)) ? intensity_cap : CAP_W'(acc_sum);
  end

  fhl_ram #(
    .WIDTH (POS_W),
    .DEPTH (HOTSPOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fhl_alu u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vld           <= '0;
      done          <= 1'b0;
      line_width    <= POS_W'(LINE_WIDTH_RST);
      intensity_cap <= CAP_W'(INTENSITY_CAP_RST);
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH:    line_width    <= cfg_data;
          REG_INTENSITY_CAP: intensity_cap <= cfg_data[CAP_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            intensity <= '0;
            position  <= '0;
            case (mode_t'(mode))
              MODE_LOAD: begin
                done <= 1'b1;
                if (in_range) begin
                  position                        <= load_pos;
                  vld[hotspot_index[IDX_W-1:0]]   <= 1'b1;
                end
              end
              MODE_MOVE: begin
                if (in_range) begin
                  idx    <= hotspot_index[IDX_W-1:0];
                  rd_idx <= hotspot_index[IDX_W-1:0];
                  step   <= value[STEP_W-1:0];
                  state  <= S_MOVE_ADD;
                end else begin
                  done <= 1'b1;
                end
              end
              MODE_RENDER: begin
                if (column < w) begin
                  col    <= column;
                  acc    <= '0;
                  cnt    <= CNT_W'(1);
                  rd_idx <= '0;
                  state  <= S_RENDER;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_MOVE_ADD: begin
          p     <= alu_y;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (wrap_lo || wrap_hi) begin
            p <= alu_y;
          end else begin
            vld[idx] <= 1'b1;
            position <= POS_W'(p);
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_RENDER: begin
          acc    <= acc_sum;
          rd_idx <= ram_raddr;
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(HOTSPOTS)) begin
            intensity <= heat_capped;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/fhl_checker.sv
// ---------------------------------------------------------------------------
// fhl_checker
// port-level checks of the fire hotspot line generator, bound to the top
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fhl_checker import fhl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [MODE_W-1:0]   mode,
  input logic                done,
  input logic [CAP_W-1:0]    intensity,
  input logic [POS_W-1:0]    position
);

  // a transaction reports either heat or a position, never both
  `CHK_IMPLY(a_one_field, clk, rst, done, (intensity == '0) || (position == '0))

  // results only come back once the sequencer is idle again
  `CHK_IMPLY(a_done_idle, clk, rst, done, !busy)

  // a load completes on the next cycle
  `CHK_NEXT(a_load_next, clk, rst, start && !busy && (mode == MODE_LOAD), done)

  // leaving a long transaction always delivers its result
  `CHK_IMPLY(a_busy_end, clk, rst, $fell(busy) && !$past(rst), done)

endmodule

bind fire_hotspot_line_generator fhl_checker u_fhl_checker (.*);
